// ===== hdl/dev_pkg.sv =====
// Shared types, constants and format decode for the encoded value decoder.
// Used by dev_decode_core and the top level dwarf_encoded_value_decoder.
package dev_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

	localparam logic [7:0] ENC_OMIT = 8'hFF;

	// low nibble of the encoding byte
	localparam logic [3:0] FMT_ABSPTR  = 4'h0;
	localparam logic [3:0] FMT_ULEB128 = 4'h1;
	localparam logic [3:0] FMT_UDATA2  = 4'h2;
	localparam logic [3:0] FMT_UDATA4  = 4'h3;
	localparam logic [3:0] FMT_UDATA8  = 4'h4;
	localparam logic [3:0] FMT_SLEB128 = 4'h9;
	localparam logic [3:0] FMT_SDATA2  = 4'hA;
	localparam logic [3:0] FMT_SDATA4  = 4'hB;
	localparam logic [3:0] FMT_SDATA8  = 4'hC;

	// bits 6:4 of the encoding byte
	localparam logic [2:0] REL_ABS = 3'd0;
	localparam logic [2:0] REL_PC  = 3'd1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_FMT   = 2'd1;
	localparam logic [1:0] ST_BAD_REL   = 2'd2;
	localparam logic [1:0] ST_INDIRECT  = 2'd3;

	localparam logic IDX_ENCODING = 1'b0;
	localparam logic IDX_BASE     = 1'b1;

	localparam logic [3:0] BYTES_MAX = 4'd15;
	localparam logic [6:0] LEB_STEP  = 7'd7;

	typedef struct packed {
		logic       supported;
		logic       is_leb;
		logic       is_signed;
		logic [3:0] need;
	} fmt_info_t;

	typedef struct packed {
		logic        we;
		logic        index;
		logic [63:0] data;
	} cfg_write_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic [1:0]  status;
	} result_t;

	function automatic fmt_info_t decode_fmt(input logic [3:0] fmt);
		fmt_info_t info;
		info = '{supported: 1'b1, is_leb: 1'b0, is_signed: 1'b0, need: 4'd0};
		case (fmt)
			FMT_ABSPTR:  info.need = 4'(VALUE_WIDTH / 8);
			FMT_ULEB128: info.is_leb = 1'b1;
			FMT_SLEB128: begin
				info.is_leb = 1'b1;
				info.is_signed = 1'b1;
			end
			FMT_UDATA2:  info.need = 4'd2;
			FMT_UDATA4:  info.need = 4'd4;
			FMT_UDATA8:  info.need = 4'd8;
			FMT_SDATA2:  begin
				info.need = 4'd2;
				info.is_signed = 1'b1;
			end
			FMT_SDATA4:  begin
				info.need = 4'd4;
				info.is_signed = 1'b1;
			end
			FMT_SDATA8:  begin
				info.need = 4'd8;
				info.is_signed = 1'b1;
			end
			default:     info.supported = 1'b0;
		endcase
		return info;
	endfunction

endpackage

// ===== hdl/dev_decode_core.sv =====
// Decode state and one-byte-per-step accumulation for the encoded value decoder.
// Holds the configuration registers and stream counters; depends on dev_pkg.
module dev_decode_core
	import dev_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_write_t cfg,
	input  logic       step,
	input  logic [7:0] byte_in,
	output result_t    res
);

	logic [7:0]  encoding_q;
	logic [63:0] acc_q;
	logic [6:0]  shift_q;
	logic [3:0]  bytes_q;
	logic [63:0] stream_pos_q;
	logic [63:0] start_pos_q;  // stream position of the value's first byte
	logic [63:0] base_pos_q;   // base address + stream position
	logic [63:0] start_base_q; // base address + offset of the value's first byte

	fmt_info_t   info;
	logic        omit;
	logic [63:0] acc_n;
	logic [6:0]  shift_n;
	logic [3:0]  bytes_n;
	logic [3:0]  bytes_inc;
	logic        done;
	logic [63:0] start_base;
	logic [63:0] acc_m;
	logic [2:0]  rel;

	assign info = decode_fmt(encoding_q[3:0]);
	assign omit = (encoding_q == ENC_OMIT);
	assign rel = encoding_q[6:4];
	assign bytes_inc = (bytes_q < BYTES_MAX) ? bytes_q + 4'd1 : bytes_q;
	assign start_base = (bytes_q == 4'd0) ? base_pos_q : start_base_q;

	always_comb begin
		acc_n = acc_q;
		shift_n = shift_q;
		bytes_n = bytes_inc;
		done = 1'b0;
		if (info.is_leb) begin
			if (!shift_q[6]) begin
				acc_n = acc_q | (64'({1'b0, byte_in[6:0]}) << shift_q[5:0]);
				shift_n = shift_q + LEB_STEP;
			end
			if (!byte_in[7]) begin
				done = 1'b1;
				if (info.is_signed && byte_in[6] && (shift_n < 7'(VALUE_WIDTH)))
					acc_n = acc_n | ({64{1'b1}} << shift_n);
			end
		end else begin
			if (!bytes_q[3])
				acc_n = acc_q | (64'(byte_in) << {bytes_q[2:0], 3'b000});
			if (bytes_inc >= info.need) begin
				done = 1'b1;
				if (info.is_signed) begin
					if (info.need == 4'd2 && acc_n[15])
						acc_n = acc_n | ({64{1'b1}} << 16);
					else if (info.need == 4'd4 && acc_n[31])
						acc_n = acc_n | ({64{1'b1}} << 32);
				end
			end
		end
	end

	assign acc_m = acc_n & VALUE_MASK;

	always_comb begin
		res.valid = step && !omit && (!info.supported || done);
		res.value = 64'd0;
		res.status = ST_OK;
		if (!info.supported) begin
			res.status = ST_BAD_FMT;
		end else if (rel != REL_ABS && rel != REL_PC) begin
			res.status = ST_BAD_REL;
		end else if (encoding_q[7]) begin
			res.status = ST_INDIRECT;
		end else if (rel == REL_PC) begin
			res.value = (acc_m + start_base) & VALUE_MASK;
		end else begin
			res.value = acc_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_q <= ENC_OMIT;
			acc_q <= '0;
			shift_q <= '0;
			bytes_q <= '0;
			stream_pos_q <= '0;
			start_pos_q <= '0;
			base_pos_q <= '0;
			start_base_q <= '0;
		end else if (cfg.we) begin
			if (cfg.index == IDX_ENCODING) begin
				encoding_q <= cfg.data[7:0];
				acc_q <= '0;
				shift_q <= '0;
				bytes_q <= '0;
			end else begin
				// rebase both sums so a value already under way sees the new base
				base_pos_q <= cfg.data + stream_pos_q;
				start_base_q <= cfg.data + start_pos_q;
			end
		end else if (step) begin
			stream_pos_q <= stream_pos_q + 64'd1;
			base_pos_q <= base_pos_q + 64'd1;
			if (bytes_q == 4'd0) begin
				start_base_q <= base_pos_q;
				start_pos_q <= stream_pos_q;
			end
			// drop partial state on omit, bad format or a finished value
			if (omit || !info.supported || done) begin
				acc_q <= '0;
				shift_q <= '0;
				bytes_q <= '0;
			end else begin
				acc_q <= acc_n;
				shift_q <= shift_n;
				bytes_q <= bytes_n;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		omit |-> !res.valid)
		else $error("result produced under omit encoding");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && !cfg.we |=> bytes_q == 4'd0 && acc_q == 64'd0)
		else $error("partial state not cleared after a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |-> res.value == 64'd0)
		else $error("error result carries a nonzero value");

endmodule

// ===== hdl/dwarf_encoded_value_decoder.sv =====
// Top level of the encoded value decoder: input register, output register and ports.
// Depends on dev_pkg and dev_decode_core.
//
// Usage:
//   Bytes of the encoded stream enter on the s_axis channel, one per beat.
//   Each finished value leaves on the m_axis channel as one beat carrying the
//   64-bit value and a 2-bit status. Bytes of an unfinished value, and all
//   bytes under the omit encoding, produce no beat.
//   The cfg port writes the encoding byte (index 0) or the stream base
//   address (index 1); write only while no byte is in flight. Writing the
//   encoding drops any partial value.
//   Path: a byte accepted from s_axis lands in the input register; the value
//   it completes is registered in the output register once that register is
//   free, and m_axis_tvalid then rises.
//   Throughput: one byte per cycle unless m_axis stalls, set by the combinational
//   accumulate and relative add between the input and output registers.
//   Reset: encoding is omit, base address and stream position are zero, both
//   registers are empty.
//   Stall: while m_axis_tready is low and a result is pending, the input
//   register holds one byte and s_axis_tready drops until the result leaves.
module dwarf_encoded_value_decoder
	import dev_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] stream_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [63:0] decoded_value, [65:64] decode_status, zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        adv;
	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_status_q;
	cfg_write_t  cfg;
	result_t     res;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};
	assign adv = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || adv;

	dev_decode_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (adv),
		.byte_in (in_byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			in_byte_s1 <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_value_q <= res.value;
			out_status_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, out_status_q, out_value_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while the result register is blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !adv |=> in_valid_s1 && $stable(in_byte_s1))
		else $error("held input byte lost or changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.valid |=> m_axis_tvalid)
		else $error("result not registered");

endmodule
